// File: design/mps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_pkg
// Types, opcodes, command codes and helpers for the motion pattern sequencer.
// ----------------------------------------------------------------------------
package mps_pkg;

  // input word kinds
  localparam logic [1:0] KIND_TIMER = 2'd0;
  localparam logic [1:0] KIND_PROG  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // opcodes
  localparam logic [7:0] OP_STEP    = 8'd0;
  localparam logic [7:0] OP_END     = 8'd1;
  localparam logic [7:0] OP_STOP    = 8'd2;
  localparam logic [7:0] OP_SUSPEND = 8'd3;
  localparam logic [7:0] OP_RESTART = 8'd4;
  localparam logic [7:0] OP_WAIT    = 8'd5;
  localparam logic [7:0] OP_SEQ     = 8'd6;
  localparam logic [7:0] OP_RET     = 8'd7;
  localparam logic [7:0] OP_REP     = 8'd8;
  localparam logic [7:0] OP_ENDREP  = 8'd9;
  localparam logic [7:0] OP_RANDSEQ = 8'd10;

  // result commands
  localparam logic [2:0] CMD_STEP    = 3'd0;
  localparam logic [2:0] CMD_WAIT    = 3'd1;
  localparam logic [2:0] CMD_SUSPEND = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;

  // results per event
  localparam int RESULT_SLOTS = 64;
  localparam int RES_W        = 7;

  typedef struct packed {
    logic [1:0]  kind;
    logic        player;
    logic [7:0]  address;
    logic [7:0]  data;
    logic [15:0] random_word;
  } in_word_t;

  typedef struct packed {
    logic       out_player;
    logic [2:0] command;
    logic [7:0] rate_index;
    logic [7:0] duration_index;
    logic [7:0] timer_id;
    logic       fault;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_OP, S_DEC, S_STEP1, S_STEP2, S_RST, S_WAIT, S_SEQ,
    S_ENT0, S_ENT1, S_REP, S_REP2, S_RET1, S_RET2, S_END1, S_END2,
    S_RS1, S_RS2, S_DIV
  } state_t;

  // Remainder of a 9-bit value by a constant divisor (>= 2): nine
  // shifted compare/subtract steps on narrow values.
  function automatic logic [8:0] mod_small(input logic [8:0] v, input logic [8:0] d);
    logic [17:0] acc;
    logic [17:0] sub;
    acc = {9'd0, v};
    for (int k = 8; k >= 0; k--) begin
      sub = {9'd0, d} << k;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    return acc[8:0];
  endfunction

endpackage
`default_nettype wire

// File: design/mps_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_divider
// Restoring remainder unit, 16-bit dividend by 8-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module mps_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mps_pkg::div_req_t req,
  output mps_pkg::div_rsp_t      rsp
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [7:0]  dsr_r, dsr_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[15]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd16;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
      end
      rem_nxt = trial[7:0];
      dvd_nxt = {dvd_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// File: design/motion_pattern_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// A write word is stored and busy stays low. A timer event runs opcode by
// opcode, paced by the single program read port and the one stack port, and
// each RANDSEQ choice also waits on the remainder unit; results leave on
// out_strobe, the final one with last set, and the receiver cannot stall.
// Throughput: one event at a time, busy high until it is done.
// Reset (sync, active low) clears player state; program and start stores keep
// their contents and must be written before use.
// ----------------------------------------------------------------------------
// motion_pattern_sequencer
// Bytecode interpreter for stepper players, run by one shared sequencer.
// ----------------------------------------------------------------------------
module motion_pattern_sequencer #(
  parameter int STACK_DEPTH   = 16,
  parameter int PROGRAM_DEPTH = 256,
  parameter int NUM_SEQUENCES = 8,
  parameter int NUM_PLAYERS   = 2,
  parameter int MAX_OPS       = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mps_pkg::in_word_t  in_word,
  output logic                    out_strobe,
  output mps_pkg::out_word_t      out_word
);

  localparam int PW  = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;
  localparam int LW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(NUM_PLAYERS * STACK_DEPTH);
  localparam int AW  = $clog2(PROGRAM_DEPTH);
  localparam int SW  = $clog2(NUM_SEQUENCES);
  localparam int OW  = $clog2(MAX_OPS + 1);

  // ---------------- storage ----------------
  logic [7:0]    prog_mem [PROGRAM_DEPTH];
  logic [7:0]    stk_mem  [NUM_PLAYERS * STACK_DEPTH];
  logic [7:0]    start_r  [NUM_SEQUENCES];

  // per-player state
  logic [7:0]    pos_arr_r [NUM_PLAYERS];
  logic [SW-1:0] seq_arr_r [NUM_PLAYERS];
  logic [LW-1:0] lvl_arr_r [NUM_PLAYERS];
  logic          halt_r    [NUM_PLAYERS];

  // working copy of the running player
  mps_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]   ply_r, ply_nxt;
  logic [7:0]      pos_r, pos_nxt;
  logic [SW-1:0]   seq_r, seq_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic [OW-1:0]   ops_r, ops_nxt;
  logic [mps_pkg::RES_W-1:0] nres_r, nres_nxt;
  logic [7:0]      arg_r, arg_nxt;
  logic [15:0]     rnd_r, rnd_nxt;

  logic            out_strobe_r;
  mps_pkg::out_word_t out_word_r;

  // memory ports
  logic [8:0]      addr_sum;
  logic [AW-1:0]   prog_raddr;
  logic [7:0]      prog_rd_r;
  logic            stk_we;
  logic [LW-1:0]   stk_widx, stk_ridx;
  logic [7:0]      stk_wdata;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [7:0]      stk_rd_r;

  // control
  logic            emit, term, do_stop, stop_fault, halt_set;
  mps_pkg::out_word_t emit_word;
  mps_pkg::div_req_t  div_req;
  mps_pkg::div_rsp_t  div_rsp;
  logic            accept;
  logic            ply_ok;
  logic [PW-1:0]   in_ply;
  logic            ovf;

  assign accept = start && !busy;
  assign in_ply = PW'(in_word.player);
  assign ply_ok = int'(in_word.player) < NUM_PLAYERS;
  assign ovf    = (int'(lvl_r) + 2) > STACK_DEPTH;

  // program fetch address: (start of sequence + offset) mod depth
  assign addr_sum   = {1'b0, start_r[seq_r]} + {1'b0, pos_r};
  assign prog_raddr = AW'(mps_pkg::mod_small(addr_sum, 9'(PROGRAM_DEPTH)));

  assign stk_waddr = SAW'(int'(ply_r) * STACK_DEPTH + int'(stk_widx));
  assign stk_raddr = SAW'(int'(ply_r) * STACK_DEPTH + int'(stk_ridx));

  // ---------------- remainder unit for RANDSEQ ----------------
  mps_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt  = state_r;
    ply_nxt    = ply_r;
    pos_nxt    = pos_r;
    seq_nxt    = seq_r;
    lvl_nxt    = lvl_r;
    ops_nxt    = ops_r;
    nres_nxt   = nres_r;
    arg_nxt    = arg_r;
    rnd_nxt    = rnd_r;
    stk_we     = 1'b0;
    stk_widx   = lvl_r;
    stk_wdata  = arg_r;
    stk_ridx   = lvl_r - LW'(1);
    emit       = 1'b0;
    term       = 1'b0;
    do_stop    = 1'b0;
    stop_fault = 1'b0;
    halt_set   = 1'b0;
    emit_word  = '0;
    emit_word.out_player = ply_r[0];
    div_req    = '0;

    unique case (state_r)
      mps_pkg::S_IDLE: begin
        if (accept && in_word.kind == mps_pkg::KIND_TIMER && ply_ok && !halt_r[in_ply]) begin
          ply_nxt   = in_ply;
          pos_nxt   = pos_arr_r[in_ply];
          seq_nxt   = seq_arr_r[in_ply];
          lvl_nxt   = lvl_arr_r[in_ply];
          ops_nxt   = '0;
          nres_nxt  = '0;
          rnd_nxt   = in_word.random_word;
          state_nxt = mps_pkg::S_OP;
        end
      end
      mps_pkg::S_OP: begin
        if (int'(ops_r) >= MAX_OPS) begin
          do_stop    = 1'b1;
          stop_fault = 1'b1;
        end else begin
          pos_nxt   = pos_r + 8'd1;
          ops_nxt   = ops_r + OW'(1);
          state_nxt = mps_pkg::S_DEC;
        end
      end
      mps_pkg::S_DEC: begin
        case (prog_rd_r)
          mps_pkg::OP_STEP: begin
            pos_nxt   = pos_r + 8'd1;
            state_nxt = mps_pkg::S_STEP1;
          end
          mps_pkg::OP_END: begin
            pos_nxt   = '0;
            state_nxt = mps_pkg::S_OP;
          end
          mps_pkg::OP_SUSPEND: begin
            emit              = 1'b1;
            term              = 1'b1;
            emit_word.command = mps_pkg::CMD_SUSPEND;
            state_nxt         = mps_pkg::S_IDLE;
          end
          mps_pkg::OP_RESTART: begin
            if (int'(nres_r) >= mps_pkg::RESULT_SLOTS - 1) begin
              do_stop    = 1'b1;
              stop_fault = 1'b1;
            end else begin
              pos_nxt   = pos_r + 8'd1;
              state_nxt = mps_pkg::S_RST;
            end
          end
          mps_pkg::OP_WAIT: begin
            pos_nxt   = pos_r + 8'd1;
            state_nxt = mps_pkg::S_WAIT;
          end
          mps_pkg::OP_SEQ: begin
            pos_nxt   = pos_r + 8'd1;
            state_nxt = mps_pkg::S_SEQ;
          end
          mps_pkg::OP_RET, mps_pkg::OP_ENDREP: begin
            if (int'(lvl_r) < 2) begin
              do_stop    = 1'b1;
              stop_fault = 1'b1;
            end else begin
              state_nxt = (prog_rd_r == mps_pkg::OP_RET) ? mps_pkg::S_RET1
                                                         : mps_pkg::S_END1;
            end
          end
          mps_pkg::OP_REP: begin
            pos_nxt   = pos_r + 8'd1;
            state_nxt = mps_pkg::S_REP;
          end
          mps_pkg::OP_RANDSEQ: begin
            pos_nxt   = pos_r + 8'd1;
            state_nxt = mps_pkg::S_RS1;
          end
          default: begin
            // STOP and any unknown byte
            do_stop = 1'b1;
          end
        endcase
      end
      mps_pkg::S_STEP1: begin
        arg_nxt   = prog_rd_r;
        pos_nxt   = pos_r + 8'd1;
        state_nxt = mps_pkg::S_STEP2;
      end
      mps_pkg::S_STEP2: begin
        emit                     = 1'b1;
        term                     = 1'b1;
        emit_word.command        = mps_pkg::CMD_STEP;
        emit_word.rate_index     = arg_r;
        emit_word.duration_index = prog_rd_r;
        state_nxt                = mps_pkg::S_IDLE;
      end
      mps_pkg::S_RST: begin
        emit               = 1'b1;
        emit_word.command  = mps_pkg::CMD_RELEASE;
        emit_word.timer_id = prog_rd_r;
        nres_nxt           = nres_r + mps_pkg::RES_W'(1);
        state_nxt          = mps_pkg::S_OP;
      end
      mps_pkg::S_WAIT: begin
        emit                     = 1'b1;
        term                     = 1'b1;
        emit_word.command        = mps_pkg::CMD_WAIT;
        emit_word.duration_index = prog_rd_r;
        state_nxt                = mps_pkg::S_IDLE;
      end
      mps_pkg::S_SEQ: begin
        arg_nxt   = prog_rd_r;
        state_nxt = mps_pkg::S_ENT0;
      end
      mps_pkg::S_ENT0: begin
        if (ovf) begin
          do_stop    = 1'b1;
          stop_fault = 1'b1;
        end else begin
          stk_we    = 1'b1;
          stk_wdata = 8'(seq_r);
          lvl_nxt   = lvl_r + LW'(1);
          state_nxt = mps_pkg::S_ENT1;
        end
      end
      mps_pkg::S_ENT1: begin
        stk_we    = 1'b1;
        stk_wdata = pos_r;
        lvl_nxt   = lvl_r + LW'(1);
        seq_nxt   = SW'(mps_pkg::mod_small({1'b0, arg_r}, 9'(NUM_SEQUENCES)));
        pos_nxt   = '0;
        state_nxt = mps_pkg::S_OP;
      end
      mps_pkg::S_REP: begin
        arg_nxt = prog_rd_r;
        if (ovf) begin
          do_stop    = 1'b1;
          stop_fault = 1'b1;
        end else begin
          stk_we    = 1'b1;
          stk_wdata = pos_r;
          lvl_nxt   = lvl_r + LW'(1);
          state_nxt = mps_pkg::S_REP2;
        end
      end
      mps_pkg::S_REP2: begin
        stk_we    = 1'b1;
        lvl_nxt   = lvl_r + LW'(1);
        state_nxt = mps_pkg::S_OP;
      end
      mps_pkg::S_RET1: begin
        pos_nxt   = stk_rd_r;
        lvl_nxt   = lvl_r - LW'(1);
        stk_ridx  = lvl_r - LW'(2);
        state_nxt = mps_pkg::S_RET2;
      end
      mps_pkg::S_RET2: begin
        seq_nxt   = SW'(mps_pkg::mod_small({1'b0, stk_rd_r}, 9'(NUM_SEQUENCES)));
        lvl_nxt   = lvl_r - LW'(1);
        state_nxt = mps_pkg::S_OP;
      end
      mps_pkg::S_END1: begin
        arg_nxt = stk_rd_r - 8'd1;
        if (stk_rd_r != 8'd1) begin
          // loop again: fetch the loop offset below the count
          stk_ridx  = lvl_r - LW'(2);
          state_nxt = mps_pkg::S_END2;
        end else begin
          lvl_nxt   = lvl_r - LW'(2);
          state_nxt = mps_pkg::S_OP;
        end
      end
      mps_pkg::S_END2: begin
        pos_nxt   = stk_rd_r;
        stk_we    = 1'b1;
        stk_widx  = lvl_r - LW'(1);
        state_nxt = mps_pkg::S_OP;
      end
      mps_pkg::S_RS1: begin
        arg_nxt   = prog_rd_r;
        pos_nxt   = pos_r + 8'd1;
        state_nxt = mps_pkg::S_RS2;
      end
      mps_pkg::S_RS2: begin
        if (prog_rd_r > arg_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = rnd_r;
          div_req.divisor  = prog_rd_r - arg_r;
          state_nxt        = mps_pkg::S_DIV;
        end else begin
          state_nxt = mps_pkg::S_ENT0;
        end
      end
      mps_pkg::S_DIV: begin
        if (div_rsp.done) begin
          arg_nxt   = arg_r + div_rsp.rem;
          state_nxt = mps_pkg::S_ENT0;
        end
      end
      default: begin
        state_nxt = mps_pkg::S_IDLE;
      end
    endcase

    if (do_stop) begin
      emit              = 1'b1;
      term              = 1'b1;
      halt_set          = 1'b1;
      emit_word.command = mps_pkg::CMD_STOP;
      emit_word.fault   = stop_fault;
      state_nxt         = mps_pkg::S_IDLE;
    end
    emit_word.last = term;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mps_pkg::S_IDLE;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < NUM_PLAYERS; i++) begin
        pos_arr_r[i] <= '0;
        seq_arr_r[i] <= SW'(i % NUM_SEQUENCES);
        lvl_arr_r[i] <= '0;
        halt_r[i]    <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= emit;
      if (term) begin
        pos_arr_r[ply_r] <= pos_nxt;
        seq_arr_r[ply_r] <= seq_nxt;
        lvl_arr_r[ply_r] <= lvl_nxt;
      end
      if (halt_set) begin
        halt_r[ply_r] <= 1'b1;
      end
    end
    ply_r  <= ply_nxt;
    pos_r  <= pos_nxt;
    seq_r  <= seq_nxt;
    lvl_r  <= lvl_nxt;
    ops_r  <= ops_nxt;
    nres_r <= nres_nxt;
    arg_r  <= arg_nxt;
    rnd_r  <= rnd_nxt;
    if (emit) begin
      out_word_r <= emit_word;
    end
  end

  // program store and sequence starts
  always_ff @(posedge clk) begin
    if (accept && in_word.kind == mps_pkg::KIND_PROG &&
        int'(in_word.address) < PROGRAM_DEPTH) begin
      prog_mem[AW'(in_word.address)] <= in_word.data;
    end
    prog_rd_r <= prog_mem[prog_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && in_word.kind == mps_pkg::KIND_START &&
        int'(in_word.address) < NUM_SEQUENCES) begin
      start_r[SW'(in_word.address)] <= in_word.data;
    end
  end

  // return stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  assign busy       = (state_r != mps_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // ---------------- assertions ----------------
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.last |-> state_r == mps_pkg::S_IDLE)
    else $error("final word while sequencer still running");

  a_mid_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_word.last |-> out_word.command == mps_pkg::CMD_RELEASE)
    else $error("non-final word is not a timer release");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> int'(lvl_r) <= STACK_DEPTH)
    else $error("stack level beyond depth");

  a_ops_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> int'(ops_r) <= MAX_OPS)
    else $error("opcode count beyond limit");

endmodule
`default_nettype wire

// File: tb/motion_pattern_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_pattern_sequencer_tb
// Loads a structured bytecode image, walks a short directed table, then runs
// random timer events against a cycle-free opcode interpreter kept in the
// bench. The run ends by driving both players into their fault stops.
// ----------------------------------------------------------------------------
module motion_pattern_sequencer_tb;
  import mps_pkg::*;

  localparam int STACK_DEPTH   = 16;
  localparam int NUM_SEQ       = 8;
  localparam int MAX_OPS       = 64;
  localparam int SEQ_SPAN      = 32;    // bytes per sequence in the image
  localparam int RANDOM_WORDS  = 300;
  localparam int WATCHDOG      = 4000;  // cycles with no word moving
  localparam int DRAIN_CYCLES  = 200;

  typedef struct {
    in_word_t  w;
    bit        typed;    // expected result written into the table
    out_word_t res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_strobe;
  out_word_t out_word;

  motion_pattern_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Interpreter copy: program and start stores, per-player position, sequence,
  // stop flag and return stack.
  // --------------------------------------------------------------------------
  logic [7:0] prog_mem [256];
  logic [7:0] seq_base [NUM_SEQ];
  logic [7:0] play_pos [2];
  logic [2:0] cur_seq  [2];
  bit         stopped  [2];
  logic [7:0] ret_stk  [2][STACK_DEPTH];
  int         stk_lvl  [2];

  out_word_t  event_cmds[$];   // commands of the event being interpreted
  out_word_t  pending_cmds[$]; // commands still owed by the block

  int fail_cnt = 0;
  int words_in = 0;
  int timer_events = 0;
  int cmds_seen = 0;
  int gap_pct = 19;
  int stall_cycles = 0;

  // image under construction and the bytes no program path can reach
  logic [7:0] img [256];
  int         spare_addr[$];

  function automatic logic [7:0] fetch_byte(input logic p);
    logic [7:0] addr;
    addr = seq_base[cur_seq[p]] + play_pos[p];   // 8-bit sum wraps the store
    play_pos[p] = play_pos[p] + 8'd1;
    return prog_mem[addr];
  endfunction

  function automatic void stk_push(input logic p, input logic [7:0] v);
    ret_stk[p][stk_lvl[p]] = v;
    stk_lvl[p]++;
  endfunction

  function automatic logic [7:0] stk_pop(input logic p);
    stk_lvl[p]--;
    return ret_stk[p][stk_lvl[p]];
  endfunction

  function automatic void enter_seq(input logic p, input logic [7:0] s);
    stk_push(p, {5'd0, cur_seq[p]});
    stk_push(p, play_pos[p]);
    cur_seq[p]  = s[2:0];
    play_pos[p] = 8'd0;
  endfunction

  function automatic void emit_cmd(input logic p, input logic [2:0] cmd,
                                   input logic [7:0] r, input logic [7:0] d,
                                   input logic [7:0] t, input logic flt);
    event_cmds.push_back('{p, cmd, r, d, t, flt, 1'b0});
  endfunction

  // Runs one player until a terminal opcode; leaves commands in event_cmds.
  task automatic run_player(input logic p, input logic [15:0] rnd);
    int         ops;
    bit         done;
    bit         flt;
    bit         halt_now;
    logic [7:0] op, r, d, cnt, lo, hi, s;
    ops = 0;
    done = 0;
    event_cmds.delete();
    while (!done) begin
      flt = 0;
      halt_now = 0;
      if (ops >= MAX_OPS) begin
        flt = 1;    // runaway: too many opcodes without a terminal one
      end else begin
        op = fetch_byte(p);
        ops++;
        case (op)
          OP_STEP: begin
            r = fetch_byte(p);
            d = fetch_byte(p);
            emit_cmd(p, CMD_STEP, r, d, 8'd0, 1'b0);
            done = 1;
          end
          OP_END: play_pos[p] = 8'd0;
          OP_SUSPEND: begin
            emit_cmd(p, CMD_SUSPEND, 8'd0, 8'd0, 8'd0, 1'b0);
            done = 1;
          end
          OP_RESTART: begin
            if (event_cmds.size() >= RESULT_SLOTS - 1) begin
              flt = 1;
            end else begin
              r = fetch_byte(p);
              emit_cmd(p, CMD_RELEASE, 8'd0, 8'd0, r, 1'b0);
            end
          end
          OP_WAIT: begin
            d = fetch_byte(p);
            emit_cmd(p, CMD_WAIT, 8'd0, d, 8'd0, 1'b0);
            done = 1;
          end
          OP_SEQ: begin
            s = fetch_byte(p);
            if (stk_lvl[p] + 2 > STACK_DEPTH) flt = 1;
            else enter_seq(p, s);
          end
          OP_RET: begin
            if (stk_lvl[p] < 2) begin
              flt = 1;
            end else begin
              play_pos[p] = stk_pop(p);
              r = stk_pop(p);
              cur_seq[p] = r[2:0];
            end
          end
          OP_REP: begin
            cnt = fetch_byte(p);
            if (stk_lvl[p] + 2 > STACK_DEPTH) begin
              flt = 1;
            end else begin
              stk_push(p, play_pos[p]);
              stk_push(p, cnt);
            end
          end
          OP_ENDREP: begin
            if (stk_lvl[p] < 2) begin
              flt = 1;
            end else begin
              cnt = stk_pop(p) - 8'd1;   // zero count wraps to 255
              if (cnt != 8'd0) begin
                play_pos[p] = ret_stk[p][stk_lvl[p] - 1];
                stk_push(p, cnt);
              end else begin
                r = stk_pop(p);
              end
            end
          end
          OP_RANDSEQ: begin
            lo = fetch_byte(p);
            hi = fetch_byte(p);
            s = lo;
            if (hi > lo) s = lo + 8'(32'(rnd) % 32'(hi - lo));
            if (stk_lvl[p] + 2 > STACK_DEPTH) flt = 1;
            else enter_seq(p, s);
          end
          default: halt_now = 1;   // STOP and any unknown byte
        endcase
      end
      if (flt || halt_now) begin
        stopped[p] = 1;
        emit_cmd(p, CMD_STOP, 8'd0, 8'd0, 8'd0, flt);
        done = 1;
      end
    end
    if (event_cmds.size() > 0) event_cmds[event_cmds.size() - 1].last = 1'b1;
  endtask

  // Applies an accepted word to the interpreter copy and queues its commands.
  task automatic apply_word(input in_word_t w, input bit typed, input out_word_t res);
    event_cmds.delete();
    case (w.kind)
      KIND_PROG:  prog_mem[w.address] = w.data;
      KIND_START: if (w.address < NUM_SEQ) seq_base[w.address[2:0]] = w.data;
      KIND_TIMER: begin
        timer_events++;
        if (!stopped[w.player]) run_player(w.player, w.random_word);
      end
      default: ;   // unused kind is dropped
    endcase
    if (typed) pending_cmds.push_back(res);
    else foreach (event_cmds[i]) pending_cmds.push_back(event_cmds[i]);
  endtask

  // Drives one word and holds it until the block takes it.
  task automatic send(input in_word_t w, input bit typed = 1'b0,
                      input out_word_t res = '0);
    in_word <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    apply_word(w, typed, res);
    words_in++;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic in_word_t tmr(input logic p, input logic [15:0] rnd);
    return '{KIND_TIMER, p, 8'($urandom), 8'($urandom), rnd};
  endfunction

  function automatic out_word_t one_cmd(input logic p, input logic [2:0] cmd,
                                        input logic [7:0] r, input logic [7:0] d);
    return '{p, cmd, r, d, 8'd0, 1'b0, 1'b1};
  endfunction

  // --------------------------------------------------------------------------
  // Image builder. Sequence s lives at 32*s. Sequences 0 and 1 are the entry
  // points and loop with END; 2..7 are subroutines that open with a terminal
  // opcode and close with RET. Calls only go to higher numbers (0,1 -> 2..7,
  // 2..4 -> 5..7) and loops only wrap terminal opcodes, so the stack stays
  // shallow and every event reaches a terminal opcode in a few steps.
  // --------------------------------------------------------------------------
  task automatic put(inout int a, input logic [7:0] b);
    img[a] = b;
    a++;
  endtask

  task automatic terminal_unit(inout int a);
    int k;
    repeat ($urandom_range(0, 2)) begin
      put(a, OP_RESTART);
      put(a, 8'($urandom));
    end
    k = $urandom_range(0, 2);
    if (k == 0) begin
      put(a, OP_STEP);
      put(a, 8'($urandom));
      put(a, 8'($urandom));
    end else if (k == 1) begin
      put(a, OP_WAIT);
      put(a, 8'($urandom));
    end else begin
      put(a, OP_SUSPEND);
    end
  endtask

  task automatic call_unit(inout int a, input int s);
    int lo;
    lo = (s < 2) ? 2 : 5;
    if ($urandom_range(0, 1) == 0) begin
      put(a, OP_SEQ);
      put(a, 8'($urandom_range(lo, 7) + 8 * $urandom_range(0, 31)));  // high bits drop
    end else begin
      put(a, OP_RANDSEQ);
      put(a, 8'($urandom_range(lo, 7)));
      put(a, 8'($urandom_range(0, 8)));
    end
  endtask

  task automatic build_image();
    int a;
    int lim;
    int k;
    spare_addr.delete();
    foreach (img[i]) img[i] = 8'($urandom);
    for (int s = 0; s < NUM_SEQ; s++) begin
      a = s * SEQ_SPAN;
      lim = a + SEQ_SPAN - 1;   // last byte kept for END or RET
      if (s == 0) begin
        // step at the rate/duration extremes, wait, suspend, releases,
        // then a random pick whose upper bound is below the lower one
        put(a, OP_STEP);    put(a, 8'hff); put(a, 8'h00);
        put(a, OP_WAIT);    put(a, 8'hff);
        put(a, OP_SUSPEND);
        put(a, OP_RESTART); put(a, 8'h00);
        put(a, OP_RESTART); put(a, 8'hff);
        put(a, OP_STEP);    put(a, 8'h00); put(a, 8'hff);
        put(a, OP_RANDSEQ); put(a, 8'd7);  put(a, 8'd3);
      end else if (s == 1) begin
        put(a, OP_WAIT);    put(a, 8'h00);
        put(a, OP_REP);     put(a, 8'd3);
        put(a, OP_WAIT);    put(a, 8'd7);
        put(a, OP_ENDREP);
        put(a, OP_SEQ);     put(a, 8'd10);   // sequence number wraps to 2
        put(a, OP_RANDSEQ); put(a, 8'd5);  put(a, 8'd8);
      end else begin
        terminal_unit(a);
      end
      while (a + 10 <= lim) begin
        k = $urandom_range(0, 3);
        if (k == 0 && s < 5) begin
          call_unit(a, s);
        end else if (k == 1 && s < 2) begin
          put(a, OP_REP);
          put(a, 8'($urandom_range(1, 4)));
          terminal_unit(a);
          put(a, OP_ENDREP);
        end else begin
          terminal_unit(a);
        end
      end
      put(a, (s < 2) ? OP_END : OP_RET);
      for (; a < (s + 1) * SEQ_SPAN; a++) spare_addr.push_back(a);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result check: every strobed command against the oldest one still owed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_strobe) begin
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        fail_cnt++;
        $error("unexpected command word %h", out_word);
      end else begin
        e = pending_cmds.pop_front();
        if (out_word.out_player !== e.out_player) begin
          fail_cnt++;
          $error("out_player exp %0d got %0d", e.out_player, out_word.out_player);
        end
        if (out_word.command !== e.command) begin
          fail_cnt++;
          $error("command exp %0d got %0d", e.command, out_word.command);
        end
        if (out_word.rate_index !== e.rate_index) begin
          fail_cnt++;
          $error("rate_index exp %0d got %0d", e.rate_index, out_word.rate_index);
        end
        if (out_word.duration_index !== e.duration_index) begin
          fail_cnt++;
          $error("duration_index exp %0d got %0d", e.duration_index,
                 out_word.duration_index);
        end
        if (out_word.timer_id !== e.timer_id) begin
          fail_cnt++;
          $error("timer_id exp %0d got %0d", e.timer_id, out_word.timer_id);
        end
        if (out_word.fault !== e.fault) begin
          fail_cnt++;
          $error("fault exp %0d got %0d", e.fault, out_word.fault);
        end
        if (out_word.last !== e.last) begin
          fail_cnt++;
          $error("last exp %0d got %0d", e.last, out_word.last);
        end
      end
    end
  end

  // Watchdog: no word taken and no command out for too long ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t dir_tab [];
    in_word_t  w;
    int        k;

    foreach (play_pos[p]) begin
      play_pos[p] = 8'd0;
      cur_seq[p]  = 3'(p);
      stopped[p]  = 0;
      stk_lvl[p]  = 0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load the image and the sequence starts
    build_image();
    for (int a = 0; a < 256; a++) send('{KIND_PROG, 1'b0, 8'(a), img[a], 16'($urandom)});
    for (int s = 0; s < NUM_SEQ; s++)
      send('{KIND_START, 1'b1, 8'(s), 8'(s * SEQ_SPAN), 16'($urandom)});

    // directed walk through the hand-written heads of sequences 0 and 1
    dir_tab = '{
      '{'{2'd3, 1'b1, 8'hff, 8'hff, 16'hffff}, 1'b0, '0},        // unused kind
      '{'{KIND_START, 1'b0, 8'd8, 8'hff, 16'h0}, 1'b0, '0},     // start index past store
      '{'{KIND_START, 1'b0, 8'hff, 8'h00, 16'h0}, 1'b0, '0},
      '{tmr(1'b0, 16'h0000), 1'b1, one_cmd(1'b0, CMD_STEP, 8'hff, 8'h00)},
      '{tmr(1'b0, 16'hffff), 1'b1, one_cmd(1'b0, CMD_WAIT, 8'h00, 8'hff)},
      '{tmr(1'b0, 16'h0000), 1'b1, one_cmd(1'b0, CMD_SUSPEND, 8'h00, 8'h00)},
      '{tmr(1'b0, 16'h1234), 1'b0, '0},                          // two releases, step
      '{tmr(1'b0, 16'hffff), 1'b0, '0},                          // random pick, empty range
      '{tmr(1'b1, 16'h0000), 1'b1, one_cmd(1'b1, CMD_WAIT, 8'h00, 8'h00)},
      '{tmr(1'b1, 16'h0000), 1'b1, one_cmd(1'b1, CMD_WAIT, 8'h00, 8'h07)},
      '{tmr(1'b1, 16'h0000), 1'b1, one_cmd(1'b1, CMD_WAIT, 8'h00, 8'h07)},
      '{tmr(1'b1, 16'h0000), 1'b1, one_cmd(1'b1, CMD_WAIT, 8'h00, 8'h07)},
      '{tmr(1'b1, 16'h0000), 1'b0, '0},                          // loop exit, call wraps
      '{tmr(1'b1, 16'hffff), 1'b0, '0},
      '{tmr(1'b1, 16'h8001), 1'b0, '0},
      '{tmr(1'b0, 16'h0000), 1'b0, '0},
      '{tmr(1'b1, 16'h7ffe), 1'b0, '0},
      '{tmr(1'b0, 16'hffff), 1'b0, '0},
      '{tmr(1'b1, 16'h0001), 1'b0, '0},
      '{tmr(1'b0, 16'h5555), 1'b0, '0}
    };
    foreach (dir_tab[i]) send(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);

    // random part: mostly timer events; writes only touch unreachable bytes
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      gap_pct = (n >= 120 && n < 200) ? 0 : 19;   // back-to-back stretch
      k = $urandom_range(0, 99);
      w = tmr(1'($urandom), 16'($urandom));
      if (k < 10) begin
        w.kind    = KIND_PROG;
        w.address = 8'(spare_addr[$urandom_range(0, spare_addr.size() - 1)]);
      end else if (k < 15) begin
        w.kind = 2'd3;
      end else if (k < 20) begin
        w.kind    = KIND_START;
        w.address = 8'($urandom_range(NUM_SEQ, 255));
      end
      send(w);
    end
    gap_pct = 19;

    // Tail: an END-only store leaves player 0 spinning until the opcode
    // limit faults it; then a SEQ-only store recurses player 1 into a stack
    // overflow. Further timer events hit stopped players and give nothing.
    for (int a = 0; a < 256; a++) send('{KIND_PROG, 1'b0, 8'(a), OP_END, 16'h0});
    send(tmr(1'b0, 16'($urandom)));
    for (int a = 0; a < 256; a++) send('{KIND_PROG, 1'b0, 8'(a), OP_SEQ, 16'h0});
    send(tmr(1'b1, 16'($urandom)));
    repeat (4) send(tmr(1'($urandom), 16'($urandom)));
    start <= 1'b0;

    // drain, then a margin for any stray command
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input words, %0d timer events, %0d commands checked",
             words_in, timer_events, cmds_seen);
    if (fail_cnt == 0 && pending_cmds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
design/mps_pkg.sv
design/mps_divider.sv
design/motion_pattern_sequencer.sv
tb/motion_pattern_sequencer_tb.sv
